@@ design/mono_glyph_pixel_expander_unit_defines.svh @@
// Assertion macros used by the checker of this block.
`ifndef MONO_GLYPH_PIXEL_EXPANDER_UNIT_DEFINES_SVH
`define MONO_GLYPH_PIXEL_EXPANDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MGE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mge: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mge: next-cycle check failed");

`endif

@@ design/mge_pkg.sv @@
`timescale 1ns / 1ps

package mge_pkg;

  // Field widths.
  localparam int unsigned AddrW   = 26;
  localparam int unsigned LineW   = 15;
  localparam int unsigned PixW    = 3;
  localparam int unsigned RowsW   = 13;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned WidthW  = 7;
  localparam int unsigned ColourW = 8;
  localparam int unsigned BitsW   = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 15;

  // Register reset values.
  localparam logic [LineW-1:0] LineBytesRst  = LineW'(1024);
  localparam logic [PixW-1:0]  PixelBytesRst = PixW'(1);
  localparam logic [RowsW-1:0] FrameRowsRst  = RowsW'(240);

  // Configuration register indices.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINE_BYTES  = 2'd0,
    CFG_PIXEL_BYTES = 2'd1,
    CFG_FRAME_ROWS  = 2'd2
  } mge_cfg_idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_CHECK,
    ST_EXPAND,
    ST_ROW_MUL,
    ST_ROW_ADD,
    ST_ROW_CLIP
  } mge_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic mul;
    logic sum;
    logic emit;
    logic row_mul;
    logic row_add;
    logic row_clip;
  } mge_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic in_start;
    logic skip;
    logic out_free;
    logic last;
    logic row_end;
  } mge_sts_t;

endpackage

@@ design/mge_intf.sv @@
`timescale 1ns / 1ps

// Glyph byte channel.
interface mge_in_if;
  import mge_pkg::*;
  logic                valid;
  logic                ready;
  logic [BitsW-1:0]    glyph_bits;
  logic                glyph_start;
  logic [CoordW-1:0]   start_x;
  logic [CoordW-1:0]   start_y;
  logic [WidthW-1:0]   glyph_width;
  logic [ColourW-1:0]  fg_colour;
  logic [ColourW-1:0]  back_colour;
  modport source (output valid, glyph_bits, glyph_start, start_x, start_y, glyph_width,
                  fg_colour, back_colour, input ready);
  modport sink (input valid, glyph_bits, glyph_start, start_x, start_y, glyph_width,
                fg_colour, back_colour, output ready);
endinterface

// Pixel write channel.
interface mge_out_if;
  import mge_pkg::*;
  logic               valid;
  logic               ready;
  logic [AddrW-1:0]   byte_address;
  logic [ColourW-1:0] pixel_colour;
  logic               last_pixel;
  modport source (output valid, byte_address, pixel_colour, last_pixel, input ready);
  modport sink (input valid, byte_address, pixel_colour, last_pixel, output ready);
endinterface

// Register write channel.
interface mge_cfg_if;
  import mge_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/mono_glyph_pixel_expander_unit.sv @@
`timescale 1ns / 1ps
// Monochrome glyph pixel expander.
// in_ch takes one bitmap byte per transfer, bit 7 leftmost; a byte flagged as
// glyph start also carries position, width and the two colours for the glyph.
// out_ch gives one framebuffer write per used bit: byte address, colour byte
// and a flag on the last write caused by that input byte.
// cfg_ch writes line length, bytes per pixel and frame height; it is always
// ready and should only be used while the block is idle.
// The first pixel of a byte reaches the output register after a check step,
// preceded on a glyph start by the start address computation, a multiply
// followed by an add. Pixels then follow one per cycle while the receiver
// takes them, up to eight a byte. The end of a row adds a row step multiply,
// address add and clip compare; a clipped or zero-width byte gives no writes.
// The single output register lets the next byte be taken while the last
// pixel still waits; when the receiver stalls, expansion pauses on that
// register. Reset restores the register defaults and clears all glyph state.
module mono_glyph_pixel_expander_unit
  import mge_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mge_in_if.sink    in_ch,
  mge_out_if.source out_ch,
  mge_cfg_if.sink   cfg_ch
);

  mge_cmd_t cmd;
  mge_sts_t sts;

  // Sequencer.
  mge_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Address and colour datapath.
  mge_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

@@ design/mge_ctrl.sv @@
`timescale 1ns / 1ps

module mge_ctrl
  import mge_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mge_sts_t sts,
  output mge_cmd_t cmd
);

  mge_state_t state_r;
  mge_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.in_valid) begin
          state_nxt = sts.in_start ? ST_MUL : ST_CHECK;
        end
      end
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = sts.skip ? ST_IDLE : ST_EXPAND;
      end
      ST_EXPAND: begin
        if (sts.out_free && sts.last) begin
          state_nxt = sts.row_end ? ST_ROW_MUL : ST_IDLE;
        end
      end
      ST_ROW_MUL:  state_nxt = ST_ROW_ADD;
      ST_ROW_ADD:  state_nxt = ST_ROW_CLIP;
      ST_ROW_CLIP: state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd          = '0;
    cmd.in_ready = (state_r == ST_IDLE);
    cmd.accept   = (state_r == ST_IDLE) && sts.in_valid;
    cmd.mul      = (state_r == ST_MUL);
    cmd.sum      = (state_r == ST_SUM);
    cmd.emit     = (state_r == ST_EXPAND) && sts.out_free;
    cmd.row_mul  = (state_r == ST_ROW_MUL);
    cmd.row_add  = (state_r == ST_ROW_ADD);
    cmd.row_clip = (state_r == ST_ROW_CLIP);
  end

endmodule

@@ design/mge_dpath.sv @@
`timescale 1ns / 1ps

module mge_dpath
  import mge_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mge_in_if.sink    in_ch,
  mge_out_if.source out_ch,
  mge_cfg_if.sink   cfg_ch,
  input  mge_cmd_t  cmd,
  output mge_sts_t  sts
);

  // Configuration registers.
  logic [LineW-1:0]   line_r;
  logic [PixW-1:0]    pix_r;
  logic [RowsW-1:0]   rows_r;

  // Glyph state.
  logic [AddrW-1:0]   offset_r;
  logic [WidthW-1:0]  rbc_r;
  logic [WidthW-1:0]  hw_r;
  logic [ColourW-1:0] fg_r;
  logic [ColourW-1:0] bg_r;
  logic               clipped_r;

  // Working registers of the current byte.
  logic [BitsW-1:0]           bits_r;
  logic [BitIdxW-1:0]         k_r;
  logic [CoordW-1:0]          x_r;
  logic [CoordW-1:0]          y_r;
  logic [CoordW+LineW-1:0]    prod_y_r;
  logic [CoordW+PixW-1:0]     prod_x_r;
  logic [AddrW-1:0]           step_r;
  logic [RowsW+LineW-1:0]     limit_r;

  // Output register.
  logic               out_valid_r;
  logic [AddrW-1:0]   out_addr_r;
  logic [ColourW-1:0] out_colour_r;
  logic               out_last_r;

  logic               cfg_fire;
  logic               row_end;
  logic               last;
  logic [WidthW+PixW-1:0] row_span;

  assign cfg_fire   = cfg_ch.valid;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = cmd.in_ready;

  assign row_end  = ((rbc_r + WidthW'(1)) == hw_r);
  assign last     = (k_r == '0) || row_end;
  assign row_span = hw_r * pix_r;

  // Status for the controller.
  always_comb begin
    sts          = '0;
    sts.in_valid = in_ch.valid;
    sts.in_start = in_ch.glyph_start;
    sts.skip     = clipped_r || (hw_r == '0);
    sts.out_free = !out_valid_r || out_ch.ready;
    sts.last     = last;
    sts.row_end  = row_end;
  end

  // Control and glyph state, set by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r      <= LineBytesRst;
      pix_r       <= PixelBytesRst;
      rows_r      <= FrameRowsRst;
      offset_r    <= '0;
      rbc_r       <= '0;
      hw_r        <= '0;
      fg_r        <= '0;
      bg_r        <= '0;
      clipped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (mge_cfg_idx_t'(cfg_ch.index))
          CFG_LINE_BYTES:  line_r <= cfg_ch.data[LineW-1:0];
          CFG_PIXEL_BYTES: pix_r  <= cfg_ch.data[PixW-1:0];
          CFG_FRAME_ROWS:  rows_r <= cfg_ch.data[RowsW-1:0];
          default: ;
        endcase
      end
      if (cmd.accept && in_ch.glyph_start) begin
        hw_r      <= in_ch.glyph_width;
        fg_r      <= in_ch.fg_colour;
        bg_r      <= in_ch.back_colour;
        rbc_r     <= '0;
        clipped_r <= 1'b0;
      end
      if (cmd.sum) begin
        offset_r <= prod_y_r[AddrW-1:0] + AddrW'(prod_x_r);
      end
      if (cmd.emit) begin
        offset_r <= offset_r + AddrW'(pix_r);
        rbc_r    <= rbc_r + WidthW'(1);
      end
      if (cmd.row_add) begin
        offset_r <= offset_r + step_r;
        rbc_r    <= '0;
      end
      if (cmd.row_clip && ({{(RowsW+LineW-AddrW){1'b0}}, offset_r} >= limit_r)) begin
        clipped_r <= 1'b1;
      end
      // The output register empties on a transfer unless refilled.
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bits_r <= in_ch.glyph_bits;
      k_r    <= BitIdxW'(BitsW - 1);
      x_r    <= in_ch.start_x;
      y_r    <= in_ch.start_y;
    end
    if (cmd.mul) begin
      prod_y_r <= y_r * line_r;
      prod_x_r <= x_r * pix_r;
    end
    if (cmd.emit) begin
      k_r          <= k_r - BitIdxW'(1);
      out_addr_r   <= offset_r;
      out_colour_r <= bits_r[k_r] ? fg_r : bg_r;
      out_last_r   <= last;
    end
    if (cmd.row_mul) begin
      step_r  <= AddrW'(line_r) - AddrW'(row_span);
      limit_r <= rows_r * line_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.byte_address = out_addr_r;
  assign out_ch.pixel_colour = out_colour_r;
  assign out_ch.last_pixel   = out_last_r;

endmodule

@@ design/mge_checker.sv @@
`timescale 1ns / 1ps
`include "mono_glyph_pixel_expander_unit_defines.svh"

module mge_checker
  import mge_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_last,
  input logic [AddrW-1:0]   out_addr,
  input logic [ColourW-1:0] out_colour
);

  // A stalled pixel write stays offered.
  `MGE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A stalled pixel write keeps its payload.
  `MGE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
                   $stable(out_addr) && $stable(out_colour) && $stable(out_last))

  // After taking a byte the block is not ready in the next cycle.
  `MGE_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready)

  // Pixels of one byte follow each other without a gap when not stalled.
  `MGE_ASSERT_NEXT(a_no_gap, clk, rst_n, out_valid && out_ready && !out_last, out_valid)

  // No new byte is taken while the current one still has pixels to give.
  `MGE_ASSERT_NOW(a_byte_order, clk, rst_n, out_valid && !out_last, !in_ready)

endmodule

bind mono_glyph_pixel_expander_unit mge_checker u_mge_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_last   (out_ch.last_pixel),
  .out_addr   (out_ch.byte_address),
  .out_colour (out_ch.pixel_colour)
);
